### src/blist_pkg.sv
// blist_pkg: shared types and constants for the bounded list unit
// depends on nothing; used by bounded_list_with_insertion_sort_unit

package blist_pkg;

	// store geometry
	localparam int DEPTH  = 256;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 16;
	localparam int DATA_W = 32;

	// operation codes
	localparam logic [2:0] KIND_PUSH_BACK  = 3'd0;
	localparam logic [2:0] KIND_PUSH_FRONT = 3'd1;
	localparam logic [2:0] KIND_POP_BACK   = 3'd2;
	localparam logic [2:0] KIND_POP_FRONT  = 3'd3;
	localparam logic [2:0] KIND_READ       = 3'd4;
	localparam logic [2:0] KIND_WRITE      = 3'd5;
	localparam logic [2:0] KIND_SORT       = 3'd6;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BOUNDS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [2:0]               kind;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [1:0]               status;
		logic [LEN_W-1:0]         length;
		logic [LEN_W-1:0]         reported_capacity;
	} rsp_t;

endpackage

### src/bounded_list_with_insertion_sort_unit.sv
// bounded_list_with_insertion_sort_unit: list store with push, pop, read, write and sort
// depends on blist_pkg for payload types, codes and store geometry
//
//  channel | valid     | stall     | payload            | direction
//  --------+-----------+-----------+--------------------+----------
//  request | req_valid | req_stall | req (req_t)        | in
//  result  | rsp_valid | rsp_stall | rsp (rsp_t)        | out
//
// push front, pop front and sort step through the store one entry at a time, bound by the
//   single memory port pair that every shift and every compare step goes through
// reset: arst_n clears length, capacity and the sequencer; the store is not cleared
// stalls: one transaction is in work at a time; req_stall is high until the sequencer
//   is back to idle, and a finished result waits in the done state while the output register holds a stalled result

module bounded_list_with_insertion_sort_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  blist_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output blist_pkg::rsp_t   rsp
);

	localparam int AW = blist_pkg::ADDR_W;
	localparam int LW = blist_pkg::LEN_W;
	localparam int DW = blist_pkg::DATA_W;

	// sequencer states, one-hot
	typedef enum logic [13:0] {
		S_IDLE        = 14'b00000000000001,
		S_DONE        = 14'b00000000000010,
		S_POP_WAIT    = 14'b00000000000100,
		S_RD_WAIT     = 14'b00000000001000,
		S_UP_RD       = 14'b00000000010000,
		S_UP_WR       = 14'b00000000100000,
		S_DN_FIRST    = 14'b00000001000000,
		S_DN_RD       = 14'b00000010000000,
		S_DN_WR       = 14'b00000100000000,
		S_SORT_LOAD   = 14'b00001000000000,
		S_SORT_HELD   = 14'b00010000000000,
		S_SORT_CMP_RD = 14'b00100000000000,
		S_SORT_CMP    = 14'b01000000000000,
		S_SORT_PLACE  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// list bookkeeping
	logic [LW-1:0] len_q;
	logic [LW-1:0] cap_q;

	// working registers of the sequencer
	logic [LW-1:0]          idx_q;   // shift pointer, also outer sort index
	logic [LW-1:0]          slot_q;  // inner sort index
	logic signed [DW-1:0]   held_q;  // entry being inserted
	logic signed [DW-1:0]   val_q;   // value captured from the request
	logic signed [DW-1:0]   data_q;
	logic [1:0]             status_q;

	// output register
	logic            rsp_valid_q;
	blist_pkg::rsp_t rsp_q;

	// element store, one write and one registered read port
	logic signed [DW-1:0] mem [blist_pkg::DEPTH];
	logic signed [DW-1:0] rd_data_q;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic signed [DW-1:0] wr_data;

	// decoded request conditions
	logic                   accept;
	logic                   full;
	logic                   empty;
	logic                   pos_oob;
	logic [LW-1:0]          len_m1;
	logic [LW:0]            cap_dbl;
	logic [LW-1:0]          cap_grown;
	logic                   out_free;
	logic                   greater;

	assign accept   = req_valid && !req_stall;
	assign full     = (len_q >= LW'(blist_pkg::DEPTH));
	assign empty    = (len_q == '0);
	assign pos_oob  = (req.position >= blist_pkg::POS_W'(len_q));
	assign len_m1   = len_q - LW'(1);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign greater  = (rd_data_q > held_q);

	// doubling rule, saturating at the store depth
	assign cap_dbl = {cap_q, 1'b0};
	always_comb begin
		if (cap_q != len_q) begin
			cap_grown = cap_q;
		end else if (cap_q == '0) begin
			cap_grown = LW'(1);
		end else if (cap_dbl > (LW + 1)'(blist_pkg::DEPTH)) begin
			cap_grown = LW'(blist_pkg::DEPTH);
		end else begin
			cap_grown = cap_dbl[LW-1:0];
		end
	end

	// memory port steering for each sequencer step
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.kind)
						blist_pkg::KIND_PUSH_BACK: begin
							wr_en   = !full;
							wr_addr = len_q[AW-1:0];
							wr_data = req.value;
						end
						blist_pkg::KIND_POP_BACK: begin
							rd_addr = len_m1[AW-1:0];
						end
						blist_pkg::KIND_POP_FRONT: begin
							rd_addr = '0;
						end
						blist_pkg::KIND_READ: begin
							rd_addr = req.position[AW-1:0];
						end
						blist_pkg::KIND_WRITE: begin
							wr_en   = !pos_oob;
							wr_addr = req.position[AW-1:0];
							wr_data = req.value;
						end
						default: begin
						end
					endcase
				end
			end
			S_UP_RD: begin
				if (idx_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = val_q;
				end else begin
					rd_addr = idx_q[AW-1:0] - AW'(1);
				end
			end
			S_UP_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0];
				wr_data = rd_data_q;
			end
			S_DN_RD: begin
				rd_addr = idx_q[AW-1:0];
			end
			S_DN_WR: begin
				wr_en   = 1'b1;
				wr_addr = idx_q[AW-1:0] - AW'(1);
				wr_data = rd_data_q;
			end
			S_SORT_LOAD: begin
				rd_addr = idx_q[AW-1:0];
			end
			S_SORT_CMP_RD: begin
				rd_addr = slot_q[AW-1:0] - AW'(1);
			end
			S_SORT_CMP: begin
				wr_en   = greater;
				wr_addr = slot_q[AW-1:0];
				wr_data = rd_data_q;
			end
			S_SORT_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = slot_q[AW-1:0];
				wr_data = held_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cap_q       <= '0;
			idx_q       <= '0;
			slot_q      <= '0;
			held_q      <= '0;
			val_q       <= '0;
			data_q      <= '0;
			status_q    <= blist_pkg::ST_OK;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// the done state loads the output register itself
			if (rsp_valid_q && !rsp_stall && state_q != S_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						data_q   <= '0;
						status_q <= blist_pkg::ST_OK;
						val_q    <= req.value;
						state_q  <= S_DONE;
						case (req.kind)
							blist_pkg::KIND_PUSH_BACK: begin
								if (full) begin
									status_q <= blist_pkg::ST_FULL;
								end else begin
									cap_q <= cap_grown;
									len_q <= len_q + LW'(1);
								end
							end
							blist_pkg::KIND_PUSH_FRONT: begin
								if (full) begin
									status_q <= blist_pkg::ST_FULL;
								end else begin
									cap_q   <= cap_grown;
									idx_q   <= len_q;
									state_q <= S_UP_RD;
								end
							end
							blist_pkg::KIND_POP_BACK: begin
								if (empty) begin
									status_q <= blist_pkg::ST_EMPTY;
								end else begin
									len_q   <= len_m1;
									state_q <= S_POP_WAIT;
								end
							end
							blist_pkg::KIND_POP_FRONT: begin
								if (empty) begin
									status_q <= blist_pkg::ST_EMPTY;
								end else begin
									state_q <= S_DN_FIRST;
								end
							end
							blist_pkg::KIND_READ: begin
								if (pos_oob) begin
									status_q <= blist_pkg::ST_BOUNDS;
								end else begin
									state_q <= S_RD_WAIT;
								end
							end
							blist_pkg::KIND_WRITE: begin
								if (pos_oob) begin
									status_q <= blist_pkg::ST_BOUNDS;
								end
							end
							blist_pkg::KIND_SORT: begin
								idx_q   <= LW'(1);
								state_q <= S_SORT_LOAD;
							end
							default: begin
							end
						endcase
					end
				end
				S_POP_WAIT, S_RD_WAIT: begin
					data_q  <= rd_data_q;
					state_q <= S_DONE;
				end
				// front push: move entries up from the top, then drop the value in slot 0
				S_UP_RD: begin
					if (idx_q == '0) begin
						len_q   <= len_q + LW'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_UP_WR;
					end
				end
				S_UP_WR: begin
					idx_q   <= idx_q - LW'(1);
					state_q <= S_UP_RD;
				end
				// front pop: take slot 0, then move entries down from slot 1
				S_DN_FIRST: begin
					data_q  <= rd_data_q;
					idx_q   <= LW'(1);
					state_q <= S_DN_RD;
				end
				S_DN_RD: begin
					if (idx_q >= len_q) begin
						len_q   <= len_m1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					idx_q   <= idx_q + LW'(1);
					state_q <= S_DN_RD;
				end
				// insertion sort, one compare or move per step
				S_SORT_LOAD: begin
					if (idx_q >= len_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_SORT_HELD;
					end
				end
				S_SORT_HELD: begin
					held_q  <= rd_data_q;
					slot_q  <= idx_q;
					state_q <= S_SORT_CMP_RD;
				end
				S_SORT_CMP_RD: begin
					if (slot_q == '0) begin
						state_q <= S_SORT_PLACE;
					end else begin
						state_q <= S_SORT_CMP;
					end
				end
				S_SORT_CMP: begin
					if (greater) begin
						slot_q  <= slot_q - LW'(1);
						state_q <= S_SORT_CMP_RD;
					end else begin
						state_q <= S_SORT_PLACE;
					end
				end
				S_SORT_PLACE: begin
					idx_q   <= idx_q + LW'(1);
					state_q <= S_SORT_LOAD;
				end
				// hand the transaction result to the output register once it is free
				S_DONE: begin
					if (out_free) begin
						rsp_q.data              <= data_q;
						rsp_q.status            <= status_q;
						rsp_q.length            <= len_q;
						rsp_q.reported_capacity <= cap_q;
						rsp_valid_q             <= 1'b1;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// length never passes the store depth
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(blist_pkg::DEPTH))
		else $error("length beyond store depth");

	// capacity always covers the stored entries
	a_cap_covers: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= cap_q)
		else $error("capacity below length");

	// an accepted transaction always takes the sequencer out of idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("sequencer stayed idle after accept");

	// inner sort index never runs past the outer one
	a_sort_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SORT_CMP_RD || state_q == S_SORT_CMP || state_q == S_SORT_PLACE)
		|-> (slot_q <= idx_q))
		else $error("sort slot beyond index");

	// a result is only loaded when the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> $stable(rsp_q))
		else $error("pending result overwritten");

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// tb: self-checking testbench for bounded_list_with_insertion_sort_unit
// depends on blist_pkg and the unit's rtl; keeps its own mirror of the list to predict results

module tb;

	localparam int DEPTH = blist_pkg::DEPTH;
	localparam int DW    = blist_pkg::DATA_W;
	localparam int PW    = blist_pkg::POS_W;
	localparam int LW    = blist_pkg::LEN_W;

	// kind code that the unit must ignore
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	// random traffic keeps the list short so sorts and shifts stay cheap
	localparam int WINDOW = 24;
	// limit on the whole run, well beyond the slowest legal run
	localparam int CYCLE_LIMIT = 3000000;
	localparam int REPORT_MAX = 10;
	localparam int HOLD_CYCLES = 400;
	// room for predictions in flight, far more than the unit can hold
	localparam int PRED_DEPTH = 8;

	logic            clk;
	logic            arst_n = 1'b0;
	logic            req_valid = 1'b0;
	logic            req_stall;
	blist_pkg::req_t req = '0;
	logic            rsp_valid;
	logic            rsp_stall = 1'b0;
	blist_pkg::rsp_t rsp;

	// long receiver hold-off, driven by the backpressure test
	logic  hold_on = 1'b0;

	// idle rates in percent for each side
	int    send_idle_pct = 0;
	int    recv_idle_pct = 0;

	int    mismatch_count = 0;
	int    cycle_count = 0;

	// mirror of the list state
	logic signed [DW-1:0] mirror_store [DEPTH];
	int    mirror_len = 0;
	int    mirror_cap = 0;

	// results predicted for accepted transactions, a ring read oldest first
	blist_pkg::rsp_t predicted [PRED_DEPTH];
	int    pred_wr_count = 0;
	int    pred_rd_count = 0;

	bounded_list_with_insertion_sort_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// cycle counter, ends a run that hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// apply one transaction to the mirror and return the result it should give
	function automatic blist_pkg::rsp_t apply_list_op(blist_pkg::req_t item);
		blist_pkg::rsp_t      r;
		int                   k;
		int                   slot;
		logic signed [DW-1:0] held;
		r = '0;
		r.status = blist_pkg::ST_OK;
		case (item.kind)
			blist_pkg::KIND_PUSH_BACK, blist_pkg::KIND_PUSH_FRONT: begin
				if (mirror_len >= DEPTH) begin
					r.status = blist_pkg::ST_FULL;
				end else begin
					// doubling rule, saturating at the store depth
					if (mirror_cap == mirror_len) begin
						mirror_cap = (mirror_cap == 0) ? 1 : mirror_cap * 2;
						if (mirror_cap > DEPTH)
							mirror_cap = DEPTH;
					end
					if (item.kind == blist_pkg::KIND_PUSH_BACK) begin
						mirror_store[mirror_len] = item.value;
					end else begin
						for (k = mirror_len; k > 0; k--)
							mirror_store[k] = mirror_store[k-1];
						mirror_store[0] = item.value;
					end
					mirror_len++;
				end
			end
			blist_pkg::KIND_POP_BACK: begin
				if (mirror_len == 0) begin
					r.status = blist_pkg::ST_EMPTY;
				end else begin
					mirror_len--;
					r.data = mirror_store[mirror_len];
				end
			end
			blist_pkg::KIND_POP_FRONT: begin
				if (mirror_len == 0) begin
					r.status = blist_pkg::ST_EMPTY;
				end else begin
					r.data = mirror_store[0];
					for (k = 1; k < mirror_len; k++)
						mirror_store[k-1] = mirror_store[k];
					mirror_len--;
				end
			end
			blist_pkg::KIND_READ: begin
				if (int'(item.position) >= mirror_len)
					r.status = blist_pkg::ST_BOUNDS;
				else
					r.data = mirror_store[item.position];
			end
			blist_pkg::KIND_WRITE: begin
				if (int'(item.position) >= mirror_len)
					r.status = blist_pkg::ST_BOUNDS;
				else
					mirror_store[item.position] = item.value;
			end
			blist_pkg::KIND_SORT: begin
				// ascending, signed compare
				for (k = 1; k < mirror_len; k++) begin
					held = mirror_store[k];
					slot = k;
					while (slot > 0 && mirror_store[slot-1] > held) begin
						mirror_store[slot] = mirror_store[slot-1];
						slot--;
					end
					mirror_store[slot] = held;
				end
			end
			default: begin
			end
		endcase
		r.length = LW'(mirror_len);
		r.reported_capacity = LW'(mirror_cap);
		return r;
	endfunction

	// mostly wide random values, with the extremes and small values that repeat
	function automatic logic signed [DW-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: begin
				return 32'sh8000_0000;
			end
			1: begin
				return 32'sh7fff_ffff;
			end
			2, 3: begin
				return DW'(int'($urandom_range(0, 8)) - 4);
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	// mostly in range, sometimes just past the end or anywhere in 16 bits
	function automatic logic [PW-1:0] rand_position();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 8 && mirror_len > 0)
			return PW'($urandom_range(0, mirror_len - 1));
		else if (pick == 9)
			return PW'($urandom);
		else
			return PW'(mirror_len + $urandom_range(0, 2));
	endfunction

	// offer one transaction, wait for it to be taken, then predict its result
	task automatic send_op(input logic [2:0] kind, input logic [PW-1:0] pos,
			input logic signed [DW-1:0] val);
		blist_pkg::req_t item;
		item.kind = kind;
		item.position = pos;
		item.value = val;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
		predicted[pred_wr_count % PRED_DEPTH] = apply_list_op(item);
		pred_wr_count++;
	endtask

	// one random transaction, kept inside the short window
	task automatic random_op();
		int         r;
		logic [2:0] kind;
		r = $urandom_range(0, 99);
		if (r < 32)
			kind = (r < 20) ? blist_pkg::KIND_PUSH_BACK : blist_pkg::KIND_PUSH_FRONT;
		else if (r < 56)
			kind = (r < 44) ? blist_pkg::KIND_POP_BACK : blist_pkg::KIND_POP_FRONT;
		else if (r < 72)
			kind = blist_pkg::KIND_READ;
		else if (r < 88)
			kind = blist_pkg::KIND_WRITE;
		else if (r < 96)
			kind = blist_pkg::KIND_SORT;
		else if (r < 98)
			kind = KIND_UNUSED;
		else
			kind = blist_pkg::KIND_PUSH_BACK;
		// turn pushes into pops once the list is long enough
		if ((kind == blist_pkg::KIND_PUSH_BACK || kind == blist_pkg::KIND_PUSH_FRONT) &&
				mirror_len >= WINDOW)
			kind = r[0] ? blist_pkg::KIND_POP_BACK : blist_pkg::KIND_POP_FRONT;
		send_op(kind, rand_position(), rand_value());
	endtask

	// extremes, every kind, empty-list and out-of-range cases
	task automatic test_directed();
		send_op(blist_pkg::KIND_POP_BACK, '0, '0);
		send_op(blist_pkg::KIND_POP_FRONT, '0, '0);
		send_op(blist_pkg::KIND_READ, '0, '0);
		send_op(blist_pkg::KIND_WRITE, '0, 32'sh1234_5678);
		send_op(blist_pkg::KIND_SORT, '0, '0);
		send_op(KIND_UNUSED, '0, '0);
		// capacity walks 1, 2, 4, 8
		send_op(blist_pkg::KIND_PUSH_BACK, '0, 32'sh7fff_ffff);
		send_op(blist_pkg::KIND_PUSH_FRONT, '0, 32'sh8000_0000);
		send_op(blist_pkg::KIND_PUSH_BACK, '0, -32'sd1);
		send_op(blist_pkg::KIND_PUSH_FRONT, '0, 32'sd0);
		send_op(blist_pkg::KIND_PUSH_BACK, '0, 32'sd1);
		send_op(blist_pkg::KIND_READ, 16'd0, '0);
		send_op(blist_pkg::KIND_READ, 16'd4, '0);
		send_op(blist_pkg::KIND_READ, 16'd5, '0);
		send_op(blist_pkg::KIND_READ, 16'hffff, '0);
		send_op(blist_pkg::KIND_WRITE, 16'd2, 32'sh5555_5555);
		send_op(blist_pkg::KIND_WRITE, 16'd5, 32'sh2aaa_aaaa);
		send_op(blist_pkg::KIND_WRITE, 16'hffff, -32'sd1);
		send_op(blist_pkg::KIND_SORT, '0, '0);
		send_op(blist_pkg::KIND_READ, 16'd0, '0);
		send_op(blist_pkg::KIND_READ, 16'd4, '0);
		send_op(blist_pkg::KIND_POP_FRONT, '0, '0);
		send_op(blist_pkg::KIND_POP_BACK, '0, '0);
		send_op(KIND_UNUSED, 16'hffff, -32'sd1);
	endtask

	// fill to depth, hit the full cases, sort the whole store, drain most of it
	task automatic test_full_store();
		int n;
		while (mirror_len < DEPTH) begin
			if (mirror_len < 16 && $urandom_range(0, 3) == 0)
				send_op(blist_pkg::KIND_PUSH_FRONT, rand_position(), rand_value());
			else
				send_op(blist_pkg::KIND_PUSH_BACK, rand_position(), rand_value());
		end
		send_op(blist_pkg::KIND_PUSH_BACK, '0, 32'sd7);
		send_op(blist_pkg::KIND_PUSH_FRONT, '0, 32'sd7);
		send_op(blist_pkg::KIND_READ, PW'(DEPTH - 1), '0);
		send_op(blist_pkg::KIND_READ, PW'(DEPTH), '0);
		send_op(blist_pkg::KIND_WRITE, PW'(DEPTH - 1), 32'sh8000_0000);
		send_op(blist_pkg::KIND_WRITE, PW'(DEPTH), 32'sd3);
		send_op(blist_pkg::KIND_SORT, '0, '0);
		send_op(blist_pkg::KIND_READ, 16'd0, '0);
		send_op(blist_pkg::KIND_READ, PW'(DEPTH - 1), '0);
		// longest shifts in both directions
		send_op(blist_pkg::KIND_POP_FRONT, '0, '0);
		send_op(blist_pkg::KIND_PUSH_FRONT, '0, 32'sh7fff_ffff);
		n = 0;
		while (mirror_len > 8) begin
			if (n % 16 == 15)
				send_op(blist_pkg::KIND_POP_FRONT, rand_position(), rand_value());
			else
				send_op(blist_pkg::KIND_POP_BACK, rand_position(), rand_value());
			n++;
		end
	endtask

	task automatic test_random_ops(input int count);
		repeat (count)
			random_op();
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_backpressure();
		fork
			begin
				int n;
				@(posedge clk);
				hold_on <= 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(posedge clk);
				hold_on <= 1'b0;
			end
			test_random_ops(12);
		join
	endtask

	// compare one result against the oldest prediction
	task automatic check_result(input blist_pkg::rsp_t got);
		blist_pkg::rsp_t want;
		if (pred_rd_count == pred_wr_count) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("unexpected result: data %0d status %0d length %0d cap %0d",
					got.data, got.status, got.length, got.reported_capacity);
		end else begin
			want = predicted[pred_rd_count % PRED_DEPTH];
			pred_rd_count++;
			if (got.data !== want.data || got.status !== want.status ||
					got.length !== want.length ||
					got.reported_capacity !== want.reported_capacity) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX) begin
					$display("mismatch: expected data %0d status %0d length %0d cap %0d",
						want.data, want.status, want.length, want.reported_capacity);
					$display("          got data %0d status %0d length %0d cap %0d",
						got.data, got.status, got.length, got.reported_capacity);
				end
			end
		end
	endtask

	// result side: random stalls plus the long hold-off, check each transaction
	always @(posedge clk) begin
		rsp_stall <= hold_on || ($urandom_range(0, 99) < recv_idle_pct);
		if (rsp_valid && !rsp_stall)
			check_result(rsp);
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// sender idles a little, receiver a lot
		send_idle_pct = 17;
		recv_idle_pct = 77;
		test_directed();
		test_full_store();
		test_random_ops(120);

		// the other way round
		send_idle_pct = 77;
		recv_idle_pct = 17;
		test_random_ops(120);
		test_backpressure();

		// no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_ops(120);

		req_valid <= 1'b0;
		while (pred_rd_count != pred_wr_count)
			@(posedge clk);
		// catch any stray result after the last one
		repeat (20) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
